// ===== src/bsf_pkg.sv =====
// Shared package for the bilinear splat framebuffer.
// Holds opcodes, the sequencer state type, defaults and the grey RGB565 packing.
// No dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 128;

	localparam logic [1:0] OP_SPLAT  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_DARKEN = 2'd3;

	localparam logic [4:0] LUMA_MAX       = 5'd31;
	localparam logic [7:0] BAND_ROWS_RST  = 8'd30;
	localparam int         WEIGHT_SHIFT   = 10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLAT_RD,
		ST_SPLAT_MUL,
		ST_SPLAT_WR,
		ST_READ,
		ST_READ_OUT,
		ST_CLEAR,
		ST_DARK_RD,
		ST_DARK_WR
	} bsf_state_t;

	// grey RGB565: red and blue take luma, green takes luma<<1
	function automatic logic [15:0] grey565(input logic [4:0] luma);
		grey565 = {luma, luma, 1'b0, luma};
	endfunction

endpackage

// ===== src/bsf_luma_ram.sv =====
// Single-port luminance store: one access per cycle, registered read data.
// Depends on nothing; depth and address width come from the top level.
`timescale 1ns / 1ps

module bsf_luma_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          re,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [4:0]    wdata,
	output logic [4:0]    rdata
);

	logic [4:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== src/bilinear_splat_framebuffer_unit.sv =====
// Top level of the bilinear splat framebuffer engine.
// Uses bsf_pkg (opcodes, state type, RGB565 packing) and bsf_luma_ram (pixel store).
`timescale 1ns / 1ps

// Grey framebuffer engine, 5-bit luminance per pixel, SCREEN_WIDTH x SCREEN_HEIGHT.
// A transfer is taken when start is high and busy is low; busy then stays high
// until the operation is finished. By opcode:
//   splat      : four corners, each read / multiply / write through the single-port
//                store and one shared multiplier; a dropped point never sets busy.
//   read pixel : the result shows on pixel_word / pixel_luma with
//                pixel_valid high for exactly one cycle and must be taken then,
//                there is no back-pressure. An off-screen read returns zero.
//   clear      : one pixel written per cycle over the whole screen.
//   darken     : each pixel of the bottom min(band_rows, SCREEN_HEIGHT) rows is
//                read, then written; an empty band never sets busy.
// The store powers up undefined: issue a clear before anything else.
// band_rows is written through cfg_we / cfg_wdata; the user must do so only while
// the engine is idle, which the block does not enforce.
module bilinear_splat_framebuffer_unit #(
	parameter int SCREEN_WIDTH  = bsf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bsf_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [13:0] x_pos,
	input  logic signed [13:0] y_pos,
	input  logic signed [6:0]  amplitude,
	input  logic [6:0]         read_col,
	input  logic [6:0]         read_row,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	output logic               pixel_valid,
	output logic [15:0]        pixel_word,
	output logic [4:0]         pixel_luma
);

	localparam int PIX_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW        = $clog2(PIX_COUNT);
	localparam int XW        = $clog2(SCREEN_WIDTH);
	localparam int YW        = $clog2(SCREEN_HEIGHT);
	localparam int CW        = 12;  // signed cell coordinate, holds -256 .. 256
	localparam int BW        = 18;  // signed bound check on the raw coordinate

	localparam logic signed [BW-1:0] X_LIM   = BW'(SCREEN_WIDTH * 32);
	localparam logic signed [BW-1:0] Y_LIM   = BW'(SCREEN_HEIGHT * 32);
	localparam logic signed [BW-1:0] LOW_LIM = -BW'(32);
	localparam logic [AW-1:0]        LAST_ADDR = AW'(PIX_COUNT - 1);

	bsf_pkg::bsf_state_t state_q, state_nx;

	logic [7:0]           band_rows_q;
	logic [AW-1:0]        sweep_q;
	logic [1:0]           corner_q;
	logic signed [CW-1:0] x0_q, y0_q;
	logic [4:0]           ax_q, ay_q;
	logic [5:0]           amp_q;
	logic [11:0]          prod_q;
	logic [5:0]           add_q;
	logic                 ok_q;
	logic [AW-1:0]        addr_q;
	logic                 pixel_valid_q;
	logic [4:0]           luma_q;

	// store port and shared multiplier
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_addr;
	logic [4:0]    mem_wdata, mem_rdata;
	logic [11:0]   mul_a;
	logic [5:0]    mul_b;
	logic [17:0]   mul_p;

	logic                 accept, splat_keep;
	logic signed [BW-1:0] fx_ext, fy_ext;
	logic signed [CW-1:0] cx, cy;
	logic                 corner_in;
	logic [AW-1:0]        corner_addr;
	logic [5:0]           wx, wy;
	logic [6:0]           sat_sum;
	logic [10:0]          rows_sat, start_row;
	logic                 rd_in;

	assign busy   = (state_q != bsf_pkg::ST_IDLE);
	assign accept = start && !busy;

	// drop test: keep points inside [-1, width] x [-1, height] with positive amplitude
	assign fx_ext     = {{(BW-14){x_pos[13]}}, x_pos};
	assign fy_ext     = {{(BW-14){y_pos[13]}}, y_pos};
	assign splat_keep = (fx_ext >= LOW_LIM) && (fx_ext <= X_LIM)
		&& (fy_ext >= LOW_LIM) && (fy_ext <= Y_LIM)
		&& !amplitude[6] && (amplitude != 7'd0);

	// current corner: bit 0 steps x, bit 1 steps y
	assign cx = x0_q + $signed({{(CW-1){1'b0}}, corner_q[0]});
	assign cy = y0_q + $signed({{(CW-1){1'b0}}, corner_q[1]});
	assign corner_in = !cx[CW-1] && !cy[CW-1]
		&& ($unsigned(cx) < CW'(SCREEN_WIDTH)) && ($unsigned(cy) < CW'(SCREEN_HEIGHT));
	assign corner_addr = AW'(AW'(cy[YW-1:0]) * AW'(SCREEN_WIDTH)) + AW'(cx[XW-1:0]);

	assign wx = corner_q[0] ? {1'b0, ax_q} : (6'd32 - {1'b0, ax_q});
	assign wy = corner_q[1] ? {1'b0, ay_q} : (6'd32 - {1'b0, ay_q});

	assign sat_sum = {2'b00, mem_rdata} + {1'b0, add_q};

	// darken band start row
	assign rows_sat  = (11'(band_rows_q) > 11'(SCREEN_HEIGHT)) ? 11'(SCREEN_HEIGHT)
		: 11'(band_rows_q);
	assign start_row = 11'(SCREEN_HEIGHT) - rows_sat;

	assign rd_in = (11'(read_col) < 11'(SCREEN_WIDTH)) && (11'(read_row) < 11'(SCREEN_HEIGHT));

	assign mul_p = 18'(mul_a) * 18'(mul_b);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bsf_pkg::ST_IDLE: begin
				if (start) begin
					case (opcode)
						bsf_pkg::OP_SPLAT:  state_nx = splat_keep ? bsf_pkg::ST_SPLAT_RD
							: bsf_pkg::ST_IDLE;
						bsf_pkg::OP_READ:   state_nx = bsf_pkg::ST_READ;
						bsf_pkg::OP_CLEAR:  state_nx = bsf_pkg::ST_CLEAR;
						bsf_pkg::OP_DARKEN: state_nx = (rows_sat != 11'd0) ? bsf_pkg::ST_DARK_RD
							: bsf_pkg::ST_IDLE;
						default:            state_nx = bsf_pkg::ST_IDLE;
					endcase
				end
			end
			bsf_pkg::ST_SPLAT_RD:  state_nx = bsf_pkg::ST_SPLAT_MUL;
			bsf_pkg::ST_SPLAT_MUL: state_nx = bsf_pkg::ST_SPLAT_WR;
			bsf_pkg::ST_SPLAT_WR:  state_nx = (corner_q == 2'd3) ? bsf_pkg::ST_IDLE
				: bsf_pkg::ST_SPLAT_RD;
			bsf_pkg::ST_READ:      state_nx = bsf_pkg::ST_READ_OUT;
			bsf_pkg::ST_READ_OUT:  state_nx = bsf_pkg::ST_IDLE;
			bsf_pkg::ST_CLEAR:     state_nx = (sweep_q == LAST_ADDR) ? bsf_pkg::ST_IDLE
				: bsf_pkg::ST_CLEAR;
			bsf_pkg::ST_DARK_RD:   state_nx = bsf_pkg::ST_DARK_WR;
			bsf_pkg::ST_DARK_WR:   state_nx = (sweep_q == LAST_ADDR) ? bsf_pkg::ST_IDLE
				: bsf_pkg::ST_DARK_RD;
			default:               state_nx = bsf_pkg::ST_IDLE;
		endcase
	end

	// store port and multiplier operands
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = sweep_q;
		mem_wdata = 5'd0;
		mul_a     = 12'(amp_q);
		mul_b     = wx;
		case (state_q)
			bsf_pkg::ST_SPLAT_RD: begin
				mem_re   = corner_in;
				mem_addr = corner_addr;
			end
			bsf_pkg::ST_SPLAT_MUL: begin
				mul_a = prod_q;
				mul_b = wy;
			end
			bsf_pkg::ST_SPLAT_WR: begin
				mem_we    = ok_q && (add_q != 6'd0);
				mem_addr  = addr_q;
				mem_wdata = (sat_sum > 7'(bsf_pkg::LUMA_MAX)) ? bsf_pkg::LUMA_MAX
					: sat_sum[4:0];
			end
			bsf_pkg::ST_READ: begin
				mem_re   = ok_q;
				mem_addr = addr_q;
			end
			bsf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			bsf_pkg::ST_DARK_RD: begin
				mem_re = 1'b1;
			end
			bsf_pkg::ST_DARK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {2'b00, mem_rdata[4:2]};
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bsf_pkg::ST_IDLE;
			band_rows_q   <= bsf_pkg::BAND_ROWS_RST;
			sweep_q       <= '0;
			corner_q      <= 2'd0;
			pixel_valid_q <= 1'b0;
		end else begin
			state_q       <= state_nx;
			pixel_valid_q <= (state_q == bsf_pkg::ST_READ_OUT);
			if (cfg_we) begin
				band_rows_q <= cfg_wdata;
			end
			if (accept) begin
				corner_q <= 2'd0;
				// an empty band leaves the sweep pointer parked
				if ((opcode == bsf_pkg::OP_DARKEN) && (rows_sat != 11'd0)) begin
					sweep_q <= AW'(AW'(start_row) * AW'(SCREEN_WIDTH));
				end
			end
			if (state_q == bsf_pkg::ST_SPLAT_WR) begin
				corner_q <= corner_q + 2'd1;
			end
			if ((state_q == bsf_pkg::ST_CLEAR) || (state_q == bsf_pkg::ST_DARK_WR)) begin
				sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + AW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q   <= {{(CW-9){x_pos[13]}}, x_pos[13:5]};
			y0_q   <= {{(CW-9){y_pos[13]}}, y_pos[13:5]};
			ax_q   <= x_pos[4:0];
			ay_q   <= y_pos[4:0];
			amp_q  <= amplitude[5:0];
			ok_q   <= rd_in;
			addr_q <= AW'(AW'(read_row) * AW'(SCREEN_WIDTH)) + AW'(read_col);
		end
		case (state_q)
			bsf_pkg::ST_SPLAT_RD: begin
				prod_q <= mul_p[11:0];
				ok_q   <= corner_in;
				addr_q <= corner_addr;
			end
			bsf_pkg::ST_SPLAT_MUL: begin
				add_q <= mul_p[bsf_pkg::WEIGHT_SHIFT +: 6];
			end
			bsf_pkg::ST_READ_OUT: begin
				luma_q <= ok_q ? mem_rdata : 5'd0;
			end
			default: begin
			end
		endcase
	end

	bsf_luma_ram #(
		.DEPTH (PIX_COUNT),
		.AW    (AW)
	) u_luma_ram (
		.clk   (clk),
		.re    (mem_re),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign pixel_valid = pixel_valid_q;
	assign pixel_luma  = luma_q;
	assign pixel_word  = bsf_pkg::grey565(luma_q);

	// a result strobe only ever follows the read output step
	a_valid_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> $past(state_q == bsf_pkg::ST_READ_OUT))
		else $error("result strobe without a read");

	// sweep pointer is parked at zero whenever the engine is idle
	a_sweep_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (sweep_q == '0))
		else $error("sweep pointer not parked");

	// the store is never written while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_we)
		else $error("store written while idle");

	// a splat leaves through its last corner with the corner count wrapped
	a_corner_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == bsf_pkg::ST_SPLAT_WR) && (state_q == bsf_pkg::ST_IDLE)
		|-> (corner_q == 2'd0))
		else $error("splat ended before all corners");

endmodule

// ===== dv/tb_bilinear_splat_framebuffer_unit.sv =====
`timescale 1ns / 1ps
// Testbench for bilinear_splat_framebuffer_unit: directed and random command streams,
// with every pixel read checked against a behavioural shadow of the luminance store.
// Depends on bsf_pkg (opcodes, screen size) and the unit's RTL.

module tb_bilinear_splat_framebuffer_unit;

	localparam int SCR_W = bsf_pkg::SCREEN_WIDTH_DEF;
	localparam int SCR_H = bsf_pkg::SCREEN_HEIGHT_DEF;
	localparam logic [7:0] BAND_AFTER_RESET = 8'd30;
	localparam int LUMA_CEIL = 31;
	localparam int PRODUCT_SHIFT = 10;
	// quiet cycles after busy drops, before a register write or the verdict
	localparam int SETTLE_CYCLES = 16;
	// longest silent stretch is a full-screen darken; the limit allows several times its length
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int PHASE_ITEMS = 104;

	typedef struct packed {
		logic [15:0] word;
		logic [4:0]  luma;
	} pixel_read_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = bsf_pkg::OP_SPLAT;
	logic signed [13:0] x_pos = '0;
	logic signed [13:0] y_pos = '0;
	logic signed [6:0]  amplitude = '0;
	logic [6:0]         read_col = '0;
	logic [6:0]         read_row = '0;
	logic               cfg_we = 1'b0;
	logic [7:0]         cfg_wdata = '0;
	logic               pixel_valid;
	logic [15:0]        pixel_word;
	logic [4:0]         pixel_luma;

	// shadow of the engine: per-pixel luminance and the band register
	logic [4:0]  shadow_luma [SCR_W*SCR_H];
	logic [7:0]  shadow_band;
	pixel_read_t pending_reads [$];

	int error_count = 0;
	int idle_cycles = 0;
	bit gapless = 1'b0;
	int last_col = 0;
	int last_row = 0;

	bilinear_splat_framebuffer_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.amplitude  (amplitude),
		.read_col   (read_col),
		.read_row   (read_row),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pixel_valid(pixel_valid),
		.pixel_word (pixel_word),
		.pixel_luma (pixel_luma)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- shadow model

	// one corner add: skipped off screen or when not positive, saturating at full scale
	task automatic add_to_pixel(input int col, input int row, input int add);
		int idx;
		int sum;
		if (col < 0 || row < 0 || col >= SCR_W || row >= SCR_H || add <= 0)
			return;
		idx = row * SCR_W + col;
		sum = int'(shadow_luma[idx]) + add;
		shadow_luma[idx] = (sum > LUMA_CEIL) ? 5'(LUMA_CEIL) : 5'(sum);
	endtask

	task automatic splat_point(input logic signed [13:0] xp, input logic signed [13:0] yp,
			input logic signed [6:0] ap);
		int fx, fy, amp, cx, cy, frac_x, frac_y;
		fx = xp;
		fy = yp;
		amp = ap;
		// points beyond one pixel outside the screen are dropped, as are non-positive amplitudes
		if (fx < -32 || fy < -32 || fx > SCR_W * 32 || fy > SCR_H * 32 || amp <= 0)
			return;
		// offset keeps the division on non-negative values, giving the floor
		cx = (fx + 32) / 32 - 1;
		cy = (fy + 32) / 32 - 1;
		frac_x = fx - cx * 32;
		frac_y = fy - cy * 32;
		add_to_pixel(cx,     cy,     (amp * (32 - frac_x) * (32 - frac_y)) >>> PRODUCT_SHIFT);
		add_to_pixel(cx + 1, cy,     (amp * frac_x * (32 - frac_y)) >>> PRODUCT_SHIFT);
		add_to_pixel(cx,     cy + 1, (amp * (32 - frac_x) * frac_y) >>> PRODUCT_SHIFT);
		add_to_pixel(cx + 1, cy + 1, (amp * frac_x * frac_y) >>> PRODUCT_SHIFT);
	endtask

	task automatic darken_band();
		int rows;
		rows = (int'(shadow_band) > SCR_H) ? SCR_H : int'(shadow_band);
		for (int r = SCR_H - rows; r < SCR_H; r++)
			for (int c = 0; c < SCR_W; c++)
				shadow_luma[r * SCR_W + c] = shadow_luma[r * SCR_W + c] >> 2;
	endtask

	// grey RGB565 worked out afresh: red and blue carry luma, green twice luma
	task automatic queue_pixel_read(input logic [6:0] col, input logic [6:0] row);
		pixel_read_t want;
		int l;
		l = (int'(col) < SCR_W && int'(row) < SCR_H) ? int'(shadow_luma[row * SCR_W + col]) : 0;
		want.luma = 5'(l);
		want.word = 16'((l << 11) | ((l << 1) << 5) | l);
		pending_reads.push_back(want);
	endtask

	task automatic update_shadow(input logic [1:0] op, input logic signed [13:0] xp,
			input logic signed [13:0] yp, input logic signed [6:0] ap,
			input logic [6:0] col, input logic [6:0] row);
		case (op)
			bsf_pkg::OP_SPLAT:  splat_point(xp, yp, ap);
			bsf_pkg::OP_READ:   queue_pixel_read(col, row);
			bsf_pkg::OP_CLEAR:  foreach (shadow_luma[i]) shadow_luma[i] = '0;
			bsf_pkg::OP_DARKEN: darken_band();
			default: begin
			end
		endcase
	endtask

	// ---------------------------------------------------------------- drivers

	// Presents one command after a random gap, or none when gapless, and holds it until the transfer.
	// start is left high so a gapless follower needs no second assignment.
	task automatic send_item(input logic [1:0] op, input logic signed [13:0] xp,
			input logic signed [13:0] yp, input logic signed [6:0] ap,
			input logic [6:0] col, input logic [6:0] row);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		x_pos     <= xp;
		y_pos     <= yp;
		amplitude <= ap;
		read_col  <= col;
		read_row  <= row;
		do @(posedge clk); while (busy);
		update_shadow(op, xp, yp, ap, col, row);
	endtask

	// unused fields carry random bits throughout
	task automatic send_splat(input int xp, input int yp, input int ap);
		last_col = xp >>> 5;
		last_row = yp >>> 5;
		send_item(bsf_pkg::OP_SPLAT, 14'(xp), 14'(yp), 7'(ap), 7'($urandom), 7'($urandom));
	endtask

	task automatic send_read(input int col, input int row);
		send_item(bsf_pkg::OP_READ, 14'($urandom), 14'($urandom), 7'($urandom), 7'(col),
			7'(row));
	endtask

	task automatic send_cmd(input logic [1:0] op);
		send_item(op, 14'($urandom), 14'($urandom), 7'($urandom), 7'($urandom),
			7'($urandom));
	endtask

	// drop start, let every read come back and the engine go quiet
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_reads.size() > 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_band(input logic [7:0] rows);
		cfg_we    <= 1'b1;
		cfg_wdata <= rows;
		@(posedge clk);
		shadow_band = rows;
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// store is undefined from power-up, so clearing comes before anything else
	task automatic test_clear_after_reset();
		send_cmd(bsf_pkg::OP_CLEAR);
		send_read(0, 0);
		send_read(SCR_W - 1, SCR_H - 1);
	endtask

	task automatic test_splat_edges();
		send_splat(-8192, 8191, 63);       // far outside: dropped
		send_splat(8191, -8192, 63);
		send_splat(-1, -1, 63);            // just left/above: only (0,0) lands, saturates
		send_splat((SCR_W - 1) * 32, (SCR_H - 1) * 32, 63);   // whole weight on last pixel
		send_splat(SCR_W * 32, 0, 63);     // on the right edge: every corner off screen
		send_splat(80, 80, 40);            // half-pixel: a quarter to each of four
		send_splat(96, 96, -64);           // non-positive amplitude changes nothing
		send_splat(96, 96, 0);
		send_read(0, 0);
		send_read(SCR_W - 1, SCR_H - 1);
		send_read(2, 2);
		send_read(3, 3);
	endtask

	task automatic test_saturation();
		send_splat(160, 160, 20);
		send_splat(160, 160, 20);
		send_read(5, 5);
	endtask

	// reset band first, then empty, over-tall and screen-sized bands
	task automatic test_darken_bands();
		send_cmd(bsf_pkg::OP_DARKEN);
		send_read(SCR_W - 1, SCR_H - 1);
		send_read(2, 2);
		wait_idle();
		write_band(8'd0);
		send_cmd(bsf_pkg::OP_DARKEN);
		send_read(SCR_W - 1, SCR_H - 1);
		wait_idle();
		write_band(8'd255);
		send_cmd(bsf_pkg::OP_DARKEN);
		send_read(0, 0);
		wait_idle();
		write_band(8'd128);
		send_cmd(bsf_pkg::OP_DARKEN);
		send_read(0, 0);
	endtask

	// Mostly well-formed splats, half into a hot patch so pixels saturate, with
	// reads mostly next to the latest splat; a few junk points, darkens and clears.
	task automatic test_random_traffic(input logic [7:0] band);
		int pick, xp, yp, ap, col, row;
		wait_idle();
		write_band(band);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n % 32 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 199);
			if (pick < 120) begin
				if ($urandom_range(0, 9) < 8) begin
					if ($urandom_range(0, 1) == 0) begin
						xp = int'($urandom_range(0, 16 * 32)) + 40 * 32;
						yp = int'($urandom_range(0, 16 * 32)) + 90 * 32;
					end else begin
						xp = int'($urandom_range(0, SCR_W * 32 + 64)) - 32;
						yp = int'($urandom_range(0, SCR_H * 32 + 64)) - 32;
					end
					ap = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 127)) - 64 :
						int'($urandom_range(1, 63));
				end else begin
					xp = int'($urandom_range(0, 16383)) - 8192;
					yp = int'($urandom_range(0, 16383)) - 8192;
					ap = int'($urandom_range(0, 127)) - 64;
				end
				send_splat(xp, yp, ap);
			end else if (pick < 188) begin
				if ($urandom_range(0, 9) < 7) begin
					col = last_col + int'($urandom_range(0, 1));
					row = last_row + int'($urandom_range(0, 1));
				end else begin
					col = $urandom_range(0, 127);
					row = $urandom_range(0, 127);
				end
				send_read(col, row);
			end else if (pick < 195) begin
				send_cmd(bsf_pkg::OP_DARKEN);
			end else begin
				send_cmd(bsf_pkg::OP_CLEAR);
			end
		end
		gapless = 1'b0;
	endtask

	// ---------------------------------------------------------------- checking

	// results cannot be held off: each strobe is compared with the oldest read
	always @(posedge clk) begin : check_results
		pixel_read_t want;
		if (arst_n && pixel_valid) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected pixel result, word %h luma %0d", $time,
					pixel_word, pixel_luma);
				error_count++;
			end else begin
				want = pending_reads.pop_front();
				if (pixel_word !== want.word) begin
					$display("%0t: pixel_word expected %h actual %h", $time, want.word,
						pixel_word);
					error_count++;
				end
				if (pixel_luma !== want.luma) begin
					$display("%0t: pixel_luma expected %0d actual %0d", $time, want.luma,
						pixel_luma);
					error_count++;
				end
			end
		end
	end

	// counts cycles with neither a command transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || pixel_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("bilinear_splat_framebuffer_unit verification failed");
			$finish;
		end
	end

	initial begin
		shadow_band = BAND_AFTER_RESET;
		foreach (shadow_luma[i]) shadow_luma[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clear_after_reset();
		test_splat_edges();
		test_saturation();
		test_darken_bands();
		test_random_traffic(8'd2);
		test_random_traffic(8'd0);
		test_random_traffic(8'd5);
		test_random_traffic(8'($urandom_range(1, 8)));
		test_random_traffic(8'd7);

		wait_idle();
		if (error_count == 0 && pending_reads.size() == 0)
			$display("bilinear_splat_framebuffer_unit verification clean");
		else
			$display("bilinear_splat_framebuffer_unit verification failed");
		$finish;
	end

endmodule
